@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by halfband_fir_filter.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hbf_pkg.sv @@
package hbf_pkg;

    // filter geometry
    localparam int FILTER_LENGTH = 23;
    localparam int PAIR_COUNT    = (FILTER_LENGTH + 1) / 4;
    localparam int CENTER_TAP    = FILTER_LENGTH / 2;
    localparam int REG_COUNT     = PAIR_COUNT + 1;
    localparam int STEP_W        = $clog2(REG_COUNT);

    // configuration register indexes
    localparam int CFG_INDEX_W   = 3;
    localparam int CENTER_REG    = PAIR_COUNT;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t LAST_STEP = step_t'(REG_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_EMIT
    } hbf_state_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  mult;
        step_t step;
        logic  acc_add;
        logic  out_load;
    } hbf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } hbf_status_t;

endpackage

@@ rtl/hbf_ctrl.sv @@
module hbf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  hbf_pkg::hbf_status_t status,
    output hbf_pkg::hbf_cmd_t  cmd
);
    import hbf_pkg::*;

    hbf_state_t state_reg, state_next;
    step_t      step_reg, step_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.step     = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // input stays closed while reset is held
                s_tready = aresetn;
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                // product of the previous step lands in the accumulator
                cmd.mult    = 1'b1;
                cmd.acc_add = (step_reg != '0);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FLUSH;
                end else begin
                    step_next = step_reg + step_t'(1);
                end
            end
            ST_FLUSH: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/hbf_datapath.sv @@
module hbf_datapath #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hbf_pkg::hbf_cmd_t             cmd,
    output hbf_pkg::hbf_status_t          status,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                          s_last,
    input  logic                          cfg_we,
    input  logic [hbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]         cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [SAMPLE_WIDTH-1:0]       m_sample,
    output logic                          m_last
);
    import hbf_pkg::*;

    localparam int PAIR_W  = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = PAIR_W + COEF_WIDTH;
    localparam int ACC_W   = PROD_W + STEP_W;
    localparam int SHIFT_W = ACC_W - (COEF_WIDTH - 1);

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (COEF_WIDTH - 2);
    localparam logic signed [SHIFT_W-1:0] SAT_MAX =
        SHIFT_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SHIFT_W-1:0] SAT_MIN = -SAT_MAX - SHIFT_W'(1);

    // past samples; the newest arriving sample is tap 0
    logic signed [SAMPLE_WIDTH-1:0] delay_reg [FILTER_LENGTH-1];
    // operand lines, one pair per step, the centre tap last
    logic signed [SAMPLE_WIDTH-1:0] opa_reg [REG_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] opb_reg [REG_COUNT];
    logic signed [COEF_WIDTH-1:0]   coef_reg [REG_COUNT];
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           be_reg;
    logic                           m_tvalid_reg;
    logic [SAMPLE_WIDTH-1:0]        m_sample_reg;
    logic                           m_last_reg;

    logic signed [PAIR_W-1:0]       pair_sum;
    logic signed [COEF_WIDTH-1:0]   coef_sel;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        rnd_sum;
    logic signed [SHIFT_W-1:0]      shifted;
    logic [SAMPLE_WIDTH-1:0]        sat_val;

    // coefficient bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                coef_reg[i] <= (i == CENTER_REG) ? (COEF_WIDTH'(1) << (COEF_WIDTH - 2)) : '0;
            end
        end else if (cfg_we && (cfg_index < CFG_INDEX_W'(REG_COUNT))) begin
            coef_reg[cfg_index[STEP_W-1:0]] <= cfg_data;
        end
    end

    // delay line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FILTER_LENGTH - 1; i++) begin
                delay_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            delay_reg[0] <= s_sample;
            for (int i = 1; i < FILTER_LENGTH - 1; i++) begin
                delay_reg[i] <= delay_reg[i-1];
            end
        end
    end

    // operand lines: loaded from the shifted taps, then stepped down
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            opa_reg[0] <= s_sample;
            for (int k = 1; k < PAIR_COUNT; k++) begin
                opa_reg[k] <= delay_reg[2*k-1];
            end
            for (int k = 0; k < PAIR_COUNT; k++) begin
                opb_reg[k] <= delay_reg[FILTER_LENGTH-2-2*k];
            end
            opa_reg[PAIR_COUNT] <= delay_reg[CENTER_TAP-1];
            opb_reg[PAIR_COUNT] <= '0;
        end else if (cmd.mult) begin
            for (int k = 0; k < REG_COUNT - 1; k++) begin
                opa_reg[k] <= opa_reg[k+1];
                opb_reg[k] <= opb_reg[k+1];
            end
            opa_reg[REG_COUNT-1] <= '0;
            opb_reg[REG_COUNT-1] <= '0;
        end
    end

    // shared pre-add and multiply
    always_comb begin
        pair_sum  = PAIR_W'(opa_reg[0]) + PAIR_W'(opb_reg[0]);
        coef_sel  = (cmd.step <= LAST_STEP) ? coef_reg[cmd.step] : coef_reg[0];
        prod_next = PROD_W'(pair_sum) * PROD_W'(coef_sel);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            prod_reg <= prod_next;
        end
    end

    // accumulator and block-end flag
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= '0;
            be_reg  <= s_last;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round to nearest, drop coefficient fraction, saturate
    always_comb begin
        rnd_sum = acc_reg + RND_BIAS;
        shifted = SHIFT_W'(rnd_sum >>> (COEF_WIDTH - 1));
        priority if (shifted > SAT_MAX) begin
            sat_val = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (shifted < SAT_MIN) begin
            sat_val = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            sat_val = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_sample_reg <= sat_val;
            m_last_reg   <= be_reg;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_sample        = m_sample_reg;
    assign m_last          = m_last_reg;

endmodule

@@ rtl/halfband_fir_filter.sv @@
// 23-tap halfband FIR filter for signed Q1.23 samples with Q1.17 coefficients. One item in
// gives one item out. The accept edge loads the tap operands, then the single shared
// pre-adder and multiplier take six symmetric pairs, then the centre tap; the last product
// is added, and the sum is rounded, saturated and loaded into the output register once it
// is free, so an item holds the block until its result is loaded. The next item is accepted
// once the result sits in the output register, even while it is still waiting to be taken.
// Coefficients must be written by the user through the cfg channel (index 0 to 5 pair taps,
// 6 centre tap) only while idle; the block does not enforce this. Writes to other indexes
// are dropped. The delay line is cleared by reset; the centre coefficient resets to one half
// and the pair coefficients to zero. Neither input channel is ready while reset is held.
`include "assert_macros.svh"

module halfband_fir_filter #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // sample_in
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  logic                                     s_tlast,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // sample_out, zero padded
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [hbf_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [COEF_WIDTH-1:0]                    cfg_data
);
    import hbf_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    hbf_cmd_t                cmd;
    hbf_status_t             status;
    logic [SAMPLE_WIDTH-1:0] m_sample;

    assign cfg_ready = aresetn;

    hbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hbf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .s_last    (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_sample  (m_sample),
        .m_last    (m_tlast)
    );

    assign m_tdata = TDATA_W'(m_sample);

    // an accepted item keeps the input closed until its result is loaded
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result is only loaded into a free output slot
    `ASSERT_IMPL(a_load_free_slot, aclk, aresetn, cmd.out_load, !m_tvalid || m_tready)

endmodule
